### design/mqf_pkg.sv
// Package for the message queue FIFO: beat payload structs, op and status codes,
// register indexes and the command and status structs between controller and datapath.
// No dependencies.
package mqf_pkg;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int CNT_W   = 5;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_RECV  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BIG   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MESSAGES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSG_SIZE = 1'd1;
   localparam logic [CNT_W-1:0]     MAX_MESSAGES_RST = 5'd16;
   localparam logic [LEN_W-1:0]     MAX_MSG_SIZE_RST = 7'd64;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [LEN_W-1:0]  limit;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              data_valid;
      logic [BYTE_W-1:0] byte_out;
      logic              end_of_run;
      logic [LEN_W-1:0]  msg_length;
      logic [CNT_W-1:0]  msg_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic send;       // store one send byte
      logic clear;      // reset pointers and count
      logic nop;        // unused op, plain ok result
      logic empty_rsp;  // receive on an empty queue
      logic rx_start;   // capture receive limit
      logic rx_len;     // length word is readable
      logic rx_byte;    // one message byte is readable
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;      // no committed message
      logic zero_len;   // receive emits no bytes
      logic byte_last;  // current byte ends the receive
   } stat_type;

endpackage

### design/mqf_ctrl.sv
// Controller for the message queue FIFO: decodes accepted beats and sequences a receive.
// Depends on mqf_pkg.
module mqf_ctrl import mqf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic [OP_W-1:0] op,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RX_LEN,
      ST_RX_BYTES
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_SEND:  cmd.send  = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_RECV: begin
                     if (stat.empty) begin
                        cmd.empty_rsp = 1'b1;
                     end else begin
                        cmd.rx_start = 1'b1;
                        state_in     = ST_RX_LEN;
                     end
                  end
                  default:  cmd.nop = 1'b1;
               endcase
            end
         end
         ST_RX_LEN: begin
            cmd.rx_len = 1'b1;
            state_in   = stat.zero_len ? ST_IDLE : ST_RX_BYTES;
         end
         ST_RX_BYTES: begin
            cmd.rx_byte = 1'b1;
            if (stat.byte_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // hold state and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

### design/mqf_datapath.sv
// Datapath for the message queue FIFO: slot memories, ring pointers, send bookkeeping,
// limit registers and the result register. Depends on mqf_pkg.
module mqf_datapath import mqf_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MSG_BYTES   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  req_type               req,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output stat_type              stat,
   output logic                  rsp_strobe,
   output rsp_type               rsp
);

   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OFS_W   = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
   localparam int ADDR_W  = IDX_W + OFS_W;
   localparam int MEM_DEPTH = QUEUE_DEPTH * (2 ** OFS_W);
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);
   localparam logic [LEN_W-1:0] MSGB_C  = LEN_W'(MSG_BYTES);

   // storage
   logic [BYTE_W-1:0] byte_mem [MEM_DEPTH];
   logic [LEN_W-1:0]  len_mem  [QUEUE_DEPTH];

   // control registers
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]  woff_ff, woff_in;
   logic [STAT_W-1:0] verdict_ff, verdict_in;
   logic [CNT_W-1:0]  max_msgs_ff;
   logic [LEN_W-1:0]  max_size_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [LEN_W-1:0]  limit_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [LEN_W-1:0]  n_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  len_rd_ff;
   logic [BYTE_W-1:0] byte_rd_ff;
   rsp_type           rsp_ff, rsp_in;

   // datapath nets
   logic [CMP_W-1:0]  eff_slots;
   logic [LEN_W-1:0]  eff_size;
   logic              full;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              len_we;
   logic [LEN_W-1:0]  len_wdata;
   logic [LEN_W-1:0]  len_clamp;
   logic [LEN_W-1:0]  rx_n;
   logic [LEN_W-1:0]  idx_next;
   logic [STAT_W-1:0] send_status;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CMP_W-1:0] slots);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(idx) + CMP_W'(1);
      if (nxt >= slots || nxt >= DEPTH_C) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

   // clamp the limit registers
   always_comb begin
      if (max_msgs_ff == '0) begin
         eff_slots = CMP_W'(1);
      end else if (CMP_W'(max_msgs_ff) > DEPTH_C) begin
         eff_slots = DEPTH_C;
      end else begin
         eff_slots = CMP_W'(max_msgs_ff);
      end
      if (max_size_ff == '0) begin
         eff_size = LEN_W'(1);
      end else if (max_size_ff > MSGB_C) begin
         eff_size = MSGB_C;
      end else begin
         eff_size = max_size_ff;
      end
   end

   assign full      = CMP_W'(count_ff) >= eff_slots;
   assign len_clamp = (len_rd_ff > MSGB_C) ? MSGB_C : len_rd_ff;
   assign rx_n      = (len_clamp < limit_ff) ? len_clamp : limit_ff;
   assign idx_next  = idx_ff + LEN_W'(1);

   assign stat.empty     = (count_ff == '0);
   assign stat.zero_len  = (rx_n == '0);
   assign stat.byte_last = (idx_next == n_ff);

   // send bookkeeping, pointer moves and result assembly
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      woff_in       = woff_ff;
      verdict_in    = verdict_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      len_we        = 1'b0;
      len_wdata     = woff_ff;
      send_status   = STAT_OK;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr_addr       = {tail_ff, woff_ff[OFS_W-1:0]};
      rd_addr       = {slot_ff, idx_next[OFS_W-1:0]};

      if (cmd.send) begin
         if (full) begin
            verdict_in = STAT_FULL;
         end else if (verdict_ff == STAT_OK) begin
            if (woff_ff >= eff_size) begin
               verdict_in = STAT_BIG;
            end else begin
               wr_en   = 1'b1;
               woff_in = woff_ff + LEN_W'(1);
            end
         end
         if (req.last) begin
            send_status = verdict_in;
            if (verdict_in == STAT_OK) begin
               // commit the length including this beat's byte
               len_we    = 1'b1;
               len_wdata = woff_in;
               tail_in   = advance(tail_ff, eff_slots);
               count_in  = count_ff + SLOT_W'(1);
            end
            woff_in    = '0;
            verdict_in = STAT_OK;
         end
      end

      if (cmd.clear) begin
         head_in    = '0;
         tail_in    = '0;
         count_in   = '0;
         woff_in    = '0;
         verdict_in = STAT_OK;
      end

      // consume the head slot and aim the first byte read
      if (cmd.rx_len) begin
         head_in  = advance(head_ff, eff_slots);
         count_in = count_ff - SLOT_W'(1);
         idx_in   = '0;
         rd_addr  = {head_ff, {OFS_W{1'b0}}};
      end

      if (cmd.rx_byte) begin
         idx_in = idx_next;
      end

      // result beat
      rsp_in.msg_count  = CNT_W'(CMP_W'(count_in));
      rsp_in.end_of_run = 1'b1;
      if (cmd.send) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = send_status;
      end
      if (cmd.clear || cmd.nop) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = STAT_OK;
      end
      if (cmd.empty_rsp) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = STAT_EMPTY;
      end
      if (cmd.rx_len && stat.zero_len) begin
         rsp_strobe_in     = 1'b1;
         rsp_in.status     = STAT_OK;
         rsp_in.msg_length = len_clamp;
      end
      if (cmd.rx_byte) begin
         rsp_strobe_in     = 1'b1;
         rsp_in.status     = STAT_OK;
         rsp_in.data_valid = 1'b1;
         rsp_in.byte_out   = byte_rd_ff;
         rsp_in.end_of_run = stat.byte_last;
         rsp_in.msg_length = len_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         woff_ff       <= '0;
         verdict_ff    <= STAT_OK;
         max_msgs_ff   <= MAX_MESSAGES_RST;
         max_size_ff   <= MAX_MSG_SIZE_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         woff_ff       <= woff_in;
         verdict_ff    <= verdict_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we && csr_index == CSR_MAX_MESSAGES) begin
            max_msgs_ff <= csr_wdata[CNT_W-1:0];
         end
         if (csr_we && csr_index == CSR_MAX_MSG_SIZE) begin
            max_size_ff <= csr_wdata[LEN_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      if (cmd.rx_start) begin
         limit_ff <= req.limit;
      end
      if (cmd.rx_len) begin
         slot_ff <= head_ff;
         n_ff    <= rx_n;
         len_ff  <= len_clamp;
      end
   end

   // byte store: write at the tail, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_mem[wr_addr] <= req.data;
      end
      byte_rd_ff <= byte_mem[rd_addr];
   end

   // length store: write at the tail on commit, registered read at the head
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[tail_ff] <= len_wdata;
      end
      len_rd_ff <= len_mem[head_ff];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

### design/message_queue_fifo.sv
// Top level of the message queue FIFO: controller plus datapath.
// Depends on mqf_pkg, mqf_ctrl and mqf_datapath.
//
// A send byte, a clear, an unused op or a receive on an empty queue leaves busy
// low; the block can take such a beat every cycle unless a receive holds busy,
// and its single result beat shows on rsp_strobe in the next cycle. A receive of
// a message with n emitted bytes (n = stored length truncated to the limit) holds
// busy while it reads the registered length word and then each byte in turn
// from the slot memory's single read port; the next beat is accepted only once
// busy falls (after the length word alone when nothing is emitted). Result beats
// come one per cycle, each for exactly one cycle, and must be taken as they come.
module message_queue_fifo import mqf_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MSG_BYTES   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   mqf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_item.op),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   mqf_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MSG_BYTES   (MSG_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

endmodule
